@@ design/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Field widths, command and fault codes, the entry type and the
// sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned SCORE_W   = 16;
  localparam int unsigned ARR_W     = 32;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned FAULT_W   = 2;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_FULL  = 2'd1,
    FAULT_EMPTY = 2'd2
  } fault_e;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ARR_W-1:0]   arrival;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_CMP,
    ST_ENQ_PUT,
    ST_DEQ_TAKE,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

@@ design/spq_if.sv @@
// ----------------------------------------------------------------------------
// spq_if: command and result channels of the sorted priority queue
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [spq_pkg::SCORE_W-1:0] new_score;
  logic [spq_pkg::ARR_W-1:0]   new_arrival;

  modport source (output valid, output cmd, output new_score, output new_arrival,
                  input ready);
  modport sink   (input valid, input cmd, input new_score, input new_arrival,
                  output ready);
endinterface

interface spq_out_if;
  logic                        valid;
  logic                        ready;
  logic                        out_valid;
  logic [spq_pkg::SCORE_W-1:0] out_score;
  logic [spq_pkg::ARR_W-1:0]   out_arrival;
  logic [spq_pkg::FAULT_W-1:0] fault;
  logic [spq_pkg::COUNT_W-1:0] entry_count;
  logic                        is_empty;
  logic                        is_full;

  modport source (output valid, output out_valid, output out_score, output out_arrival,
                  output fault, output entry_count, output is_empty, output is_full,
                  input ready);
  modport sink   (input valid, input out_valid, input out_score, input out_arrival,
                  input fault, input entry_count, input is_empty, input is_full,
                  output ready);
endinterface

`default_nettype wire

@@ design/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept in service order
// An enqueue moves lower ranked entries back one slot at a time from the
// tail; a dequeue reads the head and advances a ring pointer.
// ----------------------------------------------------------------------------
// An enqueue stays in ENQ_CMP while it moves entries back, writes the new
// entry from ENQ_CMP or ENQ_PUT and then goes to EMIT; a dequeue passes
// DEQ_TAKE and EMIT; a faulted command goes straight to EMIT. EMIT loads
// the result register once it is free or its beat is being taken. Commands are taken one at a time.
// Reset clears the count, the head pointer and the result valid flag, but
// not the result fields or the storage; the storage needs no clearing pass.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned OCW = spq_pkg::COUNT_W;
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] HEAD_LAST = AW'(DEPTH - 1);

  spq_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   head_q, head_d;
  logic [AW-1:0]   pos_q, pos_d;
  spq_pkg::entry_t new_q, new_d;
  logic            pend_valid_q, pend_valid_d;
  spq_pkg::entry_t pend_entry_q, pend_entry_d;
  spq_pkg::fault_e pend_fault_q, pend_fault_d;
  logic            out_full_q, out_full_d;
  logic            out_valid_q, out_valid_d;
  spq_pkg::entry_t out_entry_q, out_entry_d;
  spq_pkg::fault_e out_fault_q, out_fault_d;
  logic [OCW-1:0]  out_count_q, out_count_d;
  logic            out_empty_q, out_empty_d;
  logic            out_isfull_q, out_isfull_d;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  spq_pkg::entry_t mem_wdata;
  logic [AW-1:0]   mem_raddr;
  spq_pkg::entry_t mem_rdata;
  logic            below;

  logic in_fire;
  logic is_deq;
  logic q_full;
  logic q_empty;
  logic emit_go;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign in_i.ready = (state_q == spq_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_deq     = (in_i.cmd == spq_pkg::CMD_DEQ);
  assign q_full     = (count_q == CW'(DEPTH));
  assign q_empty    = (count_q == '0);
  assign emit_go    = (state_q == spq_pkg::ST_EMIT) && (!out_full_q || out_o.ready);

  spq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  spq_rank u_rank (
    .held_i  (mem_rdata),
    .cand_i  (new_q),
    .below_o (below)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      spq_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (is_deq) begin
            state_d = q_empty ? spq_pkg::ST_EMIT : spq_pkg::ST_DEQ_TAKE;
          end else if (q_full) begin
            state_d = spq_pkg::ST_EMIT;
          end else begin
            state_d = q_empty ? spq_pkg::ST_ENQ_PUT : spq_pkg::ST_ENQ_CMP;
          end
        end
      end
      spq_pkg::ST_ENQ_CMP: begin
        if (below) begin
          state_d = (pos_q == AW'(1)) ? spq_pkg::ST_ENQ_PUT : spq_pkg::ST_ENQ_CMP;
        end else begin
          state_d = spq_pkg::ST_EMIT;
        end
      end
      spq_pkg::ST_ENQ_PUT:  state_d = spq_pkg::ST_EMIT;
      spq_pkg::ST_DEQ_TAKE: state_d = spq_pkg::ST_EMIT;
      spq_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_d = spq_pkg::ST_IDLE;
        end
      end
      default: state_d = spq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    count_d      = count_q;
    head_d       = head_q;
    pos_d        = pos_q;
    new_d        = new_q;
    pend_valid_d = pend_valid_q;
    pend_entry_d = pend_entry_q;
    pend_fault_d = pend_fault_q;
    mem_we       = 1'b0;
    mem_waddr    = phys(head_q, pos_q);
    mem_wdata    = new_q;
    mem_raddr    = '0;

    case (state_q)
      spq_pkg::ST_IDLE: begin
        if (is_deq) begin
          mem_raddr = head_q;
        end else begin
          mem_raddr = phys(head_q, q_empty ? '0 : (count_q[AW-1:0] - AW'(1)));
        end
        if (in_fire) begin
          new_d.score   = in_i.new_score;
          new_d.arrival = in_i.new_arrival;
          pos_d         = count_q[AW-1:0];
          pend_valid_d  = 1'b0;
          pend_entry_d  = '0;
          if (is_deq) begin
            pend_fault_d = q_empty ? spq_pkg::FAULT_EMPTY : spq_pkg::FAULT_NONE;
          end else begin
            pend_fault_d = q_full ? spq_pkg::FAULT_FULL : spq_pkg::FAULT_NONE;
          end
        end
      end
      spq_pkg::ST_ENQ_CMP: begin
        mem_we = 1'b1;
        if (below) begin
          mem_wdata = mem_rdata;
          pos_d     = pos_q - AW'(1);
          if ({1'b0, pos_q} >= (AW + 1)'(2)) begin
            mem_raddr = phys(head_q, pos_q - AW'(2));
          end
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      spq_pkg::ST_ENQ_PUT: begin
        mem_we  = 1'b1;
        count_d = count_q + CW'(1);
      end
      spq_pkg::ST_DEQ_TAKE: begin
        pend_valid_d = 1'b1;
        pend_entry_d = mem_rdata;
        head_d       = (head_q == HEAD_LAST) ? '0 : head_q + AW'(1);
        count_d      = count_q - CW'(1);
      end
      spq_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_full_d   = out_full_q;
    out_valid_d  = out_valid_q;
    out_entry_d  = out_entry_q;
    out_fault_d  = out_fault_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    out_isfull_d = out_isfull_q;
    if (emit_go) begin
      out_full_d   = 1'b1;
      out_valid_d  = pend_valid_q;
      out_entry_d  = pend_entry_q;
      out_fault_d  = pend_fault_q;
      out_count_d  = OCW'(count_q);
      out_empty_d  = q_empty;
      out_isfull_d = q_full;
    end else if (out_full_q && out_o.ready) begin
      out_full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= spq_pkg::ST_IDLE;
      count_q    <= '0;
      head_q     <= '0;
      pos_q      <= '0;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      head_q     <= head_d;
      pos_q      <= pos_d;
      out_full_q <= out_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q        <= new_d;
    pend_valid_q <= pend_valid_d;
    pend_entry_q <= pend_entry_d;
    pend_fault_q <= pend_fault_d;
    out_valid_q  <= out_valid_d;
    out_entry_q  <= out_entry_d;
    out_fault_q  <= out_fault_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
    out_isfull_q <= out_isfull_d;
  end

  assign out_o.valid       = out_full_q;
  assign out_o.out_valid   = out_valid_q;
  assign out_o.out_score   = out_entry_q.score;
  assign out_o.out_arrival = out_entry_q.arrival;
  assign out_o.fault       = out_fault_q;
  assign out_o.entry_count = out_count_q;
  assign out_o.is_empty    = out_empty_q;
  assign out_o.is_full     = out_isfull_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_full_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_deq && q_full) |=>
      (state_q == spq_pkg::ST_EMIT && pend_fault_q == spq_pkg::FAULT_FULL))
    else $error("enqueue on full queue not flagged");

  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_deq && !q_empty) |=> ##1 (count_q == $past(count_q, 2) - CW'(1)))
    else $error("dequeue did not lower the count by one");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == spq_pkg::ST_ENQ_CMP || state_q == spq_pkg::ST_ENQ_PUT))
    else $error("storage written outside an enqueue");

  a_out_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_full_q && out_valid_q) |-> (out_fault_q == spq_pkg::FAULT_NONE))
    else $error("returned entry carries a fault");

endmodule

`default_nettype wire

@@ design/spq_mem.sv @@
// ----------------------------------------------------------------------------
// spq_mem: entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_mem #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire spq_pkg::entry_t wdata_i,
  input  wire logic [AW-1:0]   raddr_i,
  output spq_pkg::entry_t      rdata_o
);

  spq_pkg::entry_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ design/spq_rank.sv @@
// ----------------------------------------------------------------------------
// spq_rank: service order comparator
// Tells whether a held entry is served after a candidate entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_rank (
  input  wire spq_pkg::entry_t held_i,
  input  wire spq_pkg::entry_t cand_i,
  output logic                 below_o
);

  always_comb begin
    below_o = (held_i.score < cand_i.score) ||
              ((held_i.score == cand_i.score) && (held_i.arrival > cand_i.arrival));
  end

endmodule

`default_nettype wire

@@ tb/sv/sorted_priority_queue_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb: self-checking bench for the sorted priority queue
// Commands go in on the input channel, and each command accepted updates a
// local copy of the queue that predicts its result. Each result beat is
// compared field by field with the oldest prediction. Directed tests cover
// field extremes, tie ordering and dequeue while empty. Random phases
// (enqueue-heavy, dequeue-heavy, balanced) cover full, overflow and empty;
// channels idle in random bursts there, except in one mixed run and the final phase.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH     = spq_pkg::DEPTH_DEF;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic                        out_valid;
    logic [spq_pkg::SCORE_W-1:0] score;
    logic [spq_pkg::ARR_W-1:0]   arrival;
    logic [spq_pkg::FAULT_W-1:0] fault;
    logic [spq_pkg::COUNT_W-1:0] count;
    logic                        empty;
    logic                        full;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  spq_pkg::entry_t held_entries[$];
  outcome_t        pending_outcomes[$];
  int unsigned     errors = 0;
  int unsigned     idle_odds = 0;
  int unsigned     stall_odds = 0;
  int unsigned     quiet_cycles = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic outcome_t predict_outcome(input spq_pkg::cmd_e c,
                                               input logic [spq_pkg::SCORE_W-1:0] s,
                                               input logic [spq_pkg::ARR_W-1:0] a);
    outcome_t        o;
    spq_pkg::entry_t e;
    int unsigned     pos;
    o = '0;
    o.fault = spq_pkg::FAULT_NONE;
    if (c == spq_pkg::CMD_ENQ) begin
      if (held_entries.size() >= QDEPTH) begin
        o.fault = spq_pkg::FAULT_FULL;
      end else begin
        pos = 0;
        while (pos < held_entries.size() &&
               !(held_entries[pos].score < s ||
                 (held_entries[pos].score == s && held_entries[pos].arrival > a))) begin
          pos++;
        end
        e.score   = s;
        e.arrival = a;
        held_entries.insert(pos, e);
      end
    end else begin
      if (held_entries.size() == 0) begin
        o.fault = spq_pkg::FAULT_EMPTY;
      end else begin
        e           = held_entries.pop_front();
        o.out_valid = 1'b1;
        o.score     = e.score;
        o.arrival   = e.arrival;
      end
    end
    o.count = spq_pkg::COUNT_W'(held_entries.size());
    o.empty = (held_entries.size() == 0);
    o.full  = (held_entries.size() >= QDEPTH);
    return o;
  endfunction

  task automatic check_field(input string name, input logic [spq_pkg::ARR_W-1:0] want,
                             input logic [spq_pkg::ARR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      pending_outcomes.push_back(predict_outcome(spq_pkg::cmd_e'(in_ch.cmd),
                                                 in_ch.new_score, in_ch.new_arrival));
    end
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("out_valid", want.out_valid, out_ch.out_valid);
        check_field("out_score", want.score, out_ch.out_score);
        check_field("out_arrival", want.arrival, out_ch.out_arrival);
        check_field("fault", want.fault, out_ch.fault);
        check_field("entry_count", want.count, out_ch.entry_count);
        check_field("is_empty", want.empty, out_ch.is_empty);
        check_field("is_full", want.full, out_ch.is_full);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("sorted_priority_queue: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_cmd(input spq_pkg::cmd_e c, input logic [spq_pkg::SCORE_W-1:0] s,
                          input logic [spq_pkg::ARR_W-1:0] a);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= c;
    in_ch.new_score   <= s;
    in_ch.new_arrival <= a;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  function automatic logic [spq_pkg::SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 3))
      0: pick_score = ($urandom_range(0, 1) == 1) ? '1 : '0;
      1: pick_score = spq_pkg::SCORE_W'(500 + $urandom_range(0, 2));
      default: pick_score = spq_pkg::SCORE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [spq_pkg::ARR_W-1:0] pick_arrival();
    case ($urandom_range(0, 3))
      0: pick_arrival = ($urandom_range(0, 1) == 1) ? '1 : '0;
      1: pick_arrival = spq_pkg::ARR_W'($urandom_range(0, 3));
      default: pick_arrival = $urandom;
    endcase
  endfunction

  task automatic run_random(input int unsigned n, input int unsigned enq_pct);
    spq_pkg::cmd_e c;
    repeat (n) begin
      c = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ;
      send_cmd(c, pick_score(), pick_arrival());
    end
  endtask

  task automatic test_empty_dequeue();
    send_cmd(spq_pkg::CMD_DEQ, '1, '1);
  endtask

  task automatic test_field_extremes();
    send_cmd(spq_pkg::CMD_ENQ, '0, '0);
    send_cmd(spq_pkg::CMD_ENQ, '1, '1);
    send_cmd(spq_pkg::CMD_ENQ, '1, '0);
    send_cmd(spq_pkg::CMD_ENQ, '0, '1);
    repeat (4) send_cmd(spq_pkg::CMD_DEQ, '0, '0);
    send_cmd(spq_pkg::CMD_DEQ, '0, '0);
  endtask

  task automatic test_equal_scores();
    send_cmd(spq_pkg::CMD_ENQ, 16'd100, 32'd5);
    send_cmd(spq_pkg::CMD_ENQ, 16'd100, 32'd3);
    send_cmd(spq_pkg::CMD_ENQ, 16'd100, 32'd5);
    send_cmd(spq_pkg::CMD_ENQ, 16'd101, 32'd9);
    send_cmd(spq_pkg::CMD_ENQ, 16'd100, 32'd4);
    repeat (5) send_cmd(spq_pkg::CMD_DEQ, '0, '0);
  endtask

  task automatic test_fill_bias();
    idle_odds  = 4;
    stall_odds = 5;
    run_random(500, 80);
  endtask

  task automatic test_drain_bias();
    idle_odds  = 5;
    stall_odds = 4;
    run_random(400, 20);
  endtask

  task automatic test_mixed();
    idle_odds  = 3;
    stall_odds = 3;
    run_random(300, 50);
    idle_odds  = 0;
    stall_odds = 0;
    run_random(100, 55);
    idle_odds  = 6;
    stall_odds = 8;
    run_random(150, 50);
  endtask

  task automatic test_back_to_back();
    idle_odds  = 0;
    stall_odds = 0;
    run_random(300, 60);
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= spq_pkg::CMD_ENQ;
    in_ch.new_score   <= '0;
    in_ch.new_arrival <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_dequeue();
    test_field_extremes();
    test_equal_scores();
    test_fill_bias();
    test_drain_bias();
    test_mixed();
    test_back_to_back();

    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (2 * QDEPTH + 8) @(posedge clk_i);

    if (errors == 0) begin
      $display("sorted_priority_queue: match");
    end else begin
      $display("sorted_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
